@@ src/fbt_pkg.sv @@
// ----------------------------------------------------------------------------
// fbt_pkg
// Shared widths, types and helpers for the face box tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package fbt_pkg;

    localparam int COORD_BITS = 12;

    localparam int CW     = COORD_BITS;          // relative coordinate / size
    localparam int SW     = COORD_BITS + 1;      // absolute coordinate
    localparam int W3W    = COORD_BITS - 1;      // width divided by three
    localparam int NSQW   = 2 * W3W;             // squared neighborhood radius
    localparam int AREAW  = 2 * CW;              // box area
    localparam int CTRW   = SW + 1;              // box center coordinate
    localparam int DSQW   = 2 * CTRW + 1;        // squared center distance
    localparam int LIMSQW = 2 * CW;              // squared limit register
    localparam int JSQW   = 2 * SW + 1;          // squared corner move

    localparam int IN_FIELDS_W  = 6 * CW;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 * SW + 2 * CW;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Configuration register indexes
    localparam int CFG_IDXW = 1;
    localparam logic [CFG_IDXW-1:0] REG_JUMP_LIMIT  = 1'b0;
    localparam logic [CFG_IDXW-1:0] REG_MATCH_LIMIT = 1'b1;

    localparam logic [CW-1:0] JUMP_LIMIT_RESET  = CW'(60);
    localparam logic [CW-1:0] MATCH_LIMIT_RESET = CW'(100);

    // floor(v / 3) as a multiply by a rounded-up reciprocal, exact for CW bits
    localparam int DIV3_SHIFT = CW + 1;
    localparam logic [2*CW-1:0] DIV3_MUL = (2*CW)'(((1 << (CW + 1)) / 3) + 1);

    typedef enum logic [1:0] {
        MODE_SEARCH = 2'b01,
        MODE_TRACK  = 2'b10
    } mode_t;

    typedef struct packed {
        logic [SW-1:0]  x;
        logic [SW-1:0]  y;
        logic [CW-1:0]  w;
        logic [CW-1:0]  h;
        logic [W3W-1:0] w3;
        logic           present;
        logic           last;
    } cand_t;

    typedef struct packed {
        logic [SW-1:0] box_x;
        logic [SW-1:0] box_y;
        logic [CW-1:0] box_w;
        logic [CW-1:0] box_h;
        logic [SW-1:0] ref_left;
        logic [SW-1:0] ref_top;
    } res_t;

    function automatic logic [W3W-1:0] div3(input logic [CW-1:0] v);
        logic [2*CW-1:0] p;
        p = {{CW{1'b0}}, v} * DIV3_MUL;
        return p[DIV3_SHIFT +: W3W];
    endfunction

endpackage

`default_nettype wire

@@ src/fbt_in_stage.sv @@
// ----------------------------------------------------------------------------
// fbt_in_stage
// Input register: unpacks an item, forms absolute corner and width / 3.
// ----------------------------------------------------------------------------
`default_nettype none

module fbt_in_stage (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [fbt_pkg::IN_TDATA_W-1:0] s_tdata,
    input  wire logic                          s_tuser,
    input  wire logic                          s_tlast,
    output logic                               cand_valid,
    input  wire logic                          cand_ready,
    output fbt_pkg::cand_t                     cand
);

    localparam int CW = fbt_pkg::CW;
    localparam int SW = fbt_pkg::SW;

    logic           valid_reg;
    fbt_pkg::cand_t cand_reg;
    fbt_pkg::cand_t cand_next;
    logic [CW-1:0]  face_x, face_y, face_w, face_h, roi_x, roi_y;

    assign face_x = s_tdata[0*CW +: CW];
    assign face_y = s_tdata[1*CW +: CW];
    assign face_w = s_tdata[2*CW +: CW];
    assign face_h = s_tdata[3*CW +: CW];
    assign roi_x  = s_tdata[4*CW +: CW];
    assign roi_y  = s_tdata[5*CW +: CW];

    assign s_tready = !valid_reg || cand_ready;

    always_comb
    begin
        cand_next.x       = SW'(face_x) + SW'(roi_x);
        cand_next.y       = SW'(face_y) + SW'(roi_y);
        cand_next.w       = face_w;
        cand_next.h       = face_h;
        cand_next.w3      = fbt_pkg::div3(face_w);
        cand_next.present = s_tuser;
        cand_next.last    = s_tlast;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cand_reg <= cand_next;
        end
    end

    assign cand_valid = valid_reg;
    assign cand       = cand_reg;

endmodule

`default_nettype wire

@@ src/fbt_select.sv @@
// ----------------------------------------------------------------------------
// fbt_select
// Per-frame box selection: largest area in search, nearest center in track.
// ----------------------------------------------------------------------------
`default_nettype none

module fbt_select (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cand_valid,
    output logic                         cand_ready,
    input  wire fbt_pkg::cand_t          cand,
    input  wire logic [fbt_pkg::CW-1:0]  match_limit,
    output logic                         res_valid,
    input  wire logic                    res_ready,
    output fbt_pkg::res_t                res
);

    localparam int CW     = fbt_pkg::CW;
    localparam int SW     = fbt_pkg::SW;
    localparam int NSQW   = fbt_pkg::NSQW;
    localparam int AREAW  = fbt_pkg::AREAW;
    localparam int CTRW   = fbt_pkg::CTRW;
    localparam int DSQW   = fbt_pkg::DSQW;
    localparam int LIMSQW = fbt_pkg::LIMSQW;

    fbt_pkg::mode_t     mode_reg;
    logic               frame_start_reg;
    logic               any_reg;
    logic [AREAW-1:0]   area_reg;
    logic [LIMSQW-1:0]  dist_reg;
    logic [SW-1:0]      best_left_reg, best_top_reg;
    logic [CW-1:0]      best_width_reg, best_height_reg;
    logic [NSQW-1:0]    best_nsq_reg;
    logic [SW-1:0]      ref_left_reg, ref_top_reg;
    logic [CW-1:0]      ref_width_reg, ref_height_reg;
    logic [NSQW-1:0]    ref_nsq_reg;
    logic               res_valid_reg;
    fbt_pkg::res_t      res_reg;

    logic               fire;
    logic               tracking;
    logic [LIMSQW-1:0]  ml_sq;
    logic [AREAW-1:0]   cand_area;
    logic [NSQW-1:0]    cand_nsq;
    logic [CTRW-1:0]    ref_cx, ref_cy, cand_cx, cand_cy, dx, dy;
    logic [2*CTRW-1:0]  dx_sq, dy_sq;
    logic [DSQW-1:0]    dsq;
    logic               take_area, take_dist;

    logic               any_base, any_next;
    logic [AREAW-1:0]   area_base, area_next;
    logic [LIMSQW-1:0]  dist_base, dist_next;
    logic [SW-1:0]      left_base, top_base, left_next, top_next;
    logic [CW-1:0]      width_base, height_base, width_next, height_next;
    logic [NSQW-1:0]    nsq_base, nsq_next;

    fbt_pkg::mode_t     mode_next;
    logic [SW-1:0]      ref_left_next, ref_top_next;
    logic [CW-1:0]      ref_width_next, ref_height_next;
    logic [NSQW-1:0]    ref_nsq_next;
    fbt_pkg::res_t      res_next;

    assign tracking   = (mode_reg == fbt_pkg::MODE_TRACK);
    assign cand_ready = !res_valid_reg || res_ready;
    assign fire       = cand_valid && cand_ready;

    assign ml_sq     = match_limit * match_limit;
    assign cand_area = cand.w * cand.h;
    assign cand_nsq  = cand.w3 * cand.w3;

    assign ref_cx  = CTRW'(ref_left_reg) + CTRW'(ref_width_reg[CW-1:1]);
    assign ref_cy  = CTRW'(ref_top_reg) + CTRW'(ref_height_reg[CW-1:1]);
    assign cand_cx = CTRW'(cand.x) + CTRW'(cand.w[CW-1:1]);
    assign cand_cy = CTRW'(cand.y) + CTRW'(cand.h[CW-1:1]);
    assign dx      = (ref_cx > cand_cx) ? (ref_cx - cand_cx) : (cand_cx - ref_cx);
    assign dy      = (ref_cy > cand_cy) ? (ref_cy - cand_cy) : (cand_cy - ref_cy);
    assign dx_sq   = dx * dx;
    assign dy_sq   = dy * dy;
    assign dsq     = DSQW'(dx_sq) + DSQW'(dy_sq);

    // Accumulators restart on the first item of a frame
    always_comb
    begin
        if (frame_start_reg)
        begin
            any_base  = 1'b0;
            area_base = '0;
            dist_base = ml_sq;
            if (tracking)
            begin
                left_base   = ref_left_reg;
                top_base    = ref_top_reg;
                width_base  = ref_width_reg;
                height_base = ref_height_reg;
                nsq_base    = ref_nsq_reg;
            end
            else
            begin
                left_base   = '0;
                top_base    = '0;
                width_base  = '0;
                height_base = '0;
                nsq_base    = '0;
            end
        end
        else
        begin
            any_base    = any_reg;
            area_base   = area_reg;
            dist_base   = dist_reg;
            left_base   = best_left_reg;
            top_base    = best_top_reg;
            width_base  = best_width_reg;
            height_base = best_height_reg;
            nsq_base    = best_nsq_reg;
        end
    end

    assign take_area = cand.present && !tracking && (cand_area > area_base);
    assign take_dist = cand.present && tracking
                       && (dsq <= DSQW'(ref_nsq_reg))
                       && (dsq < DSQW'(dist_base));

    always_comb
    begin
        any_next    = any_base || cand.present;
        area_next   = take_area ? cand_area : area_base;
        dist_next   = take_dist ? LIMSQW'(dsq) : dist_base;
        left_next   = (take_area || take_dist) ? cand.x : left_base;
        top_next    = (take_area || take_dist) ? cand.y : top_base;
        width_next  = (take_area || take_dist) ? cand.w : width_base;
        height_next = (take_area || take_dist) ? cand.h : height_base;
        nsq_next    = take_area ? cand_nsq : nsq_base;
    end

    // Frame end: pick result, update mode and reference
    always_comb
    begin
        mode_next       = mode_reg;
        ref_left_next   = ref_left_reg;
        ref_top_next    = ref_top_reg;
        ref_width_next  = ref_width_reg;
        ref_height_next = ref_height_reg;
        ref_nsq_next    = ref_nsq_reg;
        res_next.box_x  = '0;
        res_next.box_y  = '0;
        res_next.box_w  = '0;
        res_next.box_h  = '0;
        if (!any_next)
        begin
            mode_next = fbt_pkg::MODE_SEARCH;
        end
        else
        begin
            res_next.box_x = left_next;
            res_next.box_y = top_next;
            res_next.box_w = width_next;
            res_next.box_h = height_next;
            unique case (mode_reg)
                fbt_pkg::MODE_SEARCH:
                begin
                    ref_left_next   = left_next;
                    ref_top_next    = top_next;
                    ref_width_next  = width_next;
                    ref_height_next = height_next;
                    ref_nsq_next    = nsq_next;
                    mode_next = (area_next != '0) ? fbt_pkg::MODE_TRACK
                                                  : fbt_pkg::MODE_SEARCH;
                end
                fbt_pkg::MODE_TRACK:
                begin
                    mode_next = fbt_pkg::MODE_TRACK;
                end
                default:
                begin
                    mode_next = fbt_pkg::MODE_SEARCH;
                end
            endcase
        end
        res_next.ref_left = ref_left_next;
        res_next.ref_top  = ref_top_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= fbt_pkg::MODE_SEARCH;
            frame_start_reg <= 1'b1;
            res_valid_reg   <= 1'b0;
            ref_left_reg    <= '0;
            ref_top_reg     <= '0;
            ref_width_reg   <= '0;
            ref_height_reg  <= '0;
            ref_nsq_reg     <= '0;
        end
        else
        begin
            if (fire)
            begin
                frame_start_reg <= cand.last;
                if (cand.last)
                begin
                    mode_reg       <= mode_next;
                    ref_left_reg   <= ref_left_next;
                    ref_top_reg    <= ref_top_next;
                    ref_width_reg  <= ref_width_next;
                    ref_height_reg <= ref_height_next;
                    ref_nsq_reg    <= ref_nsq_next;
                end
            end
            if (fire && cand.last)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            any_reg         <= any_next;
            area_reg        <= area_next;
            dist_reg        <= dist_next;
            best_left_reg   <= left_next;
            best_top_reg    <= top_next;
            best_width_reg  <= width_next;
            best_height_reg <= height_next;
            best_nsq_reg    <= nsq_next;
        end
        if (fire && cand.last)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Tracking is entered only when a frame closes
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(tracking) |-> $past(fire && cand.last))
        else $error("tracking entered outside a frame end");

    // Reference holds while tracking
    assert property (@(posedge clk) disable iff (!rst_n)
        tracking |=> ($stable(ref_left_reg) && $stable(ref_top_reg)
                      && $stable(ref_width_reg) && $stable(ref_height_reg)))
        else $error("reference changed in tracking mode");

    // A frame end always starts a fresh frame and posts a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && cand.last) |=> (frame_start_reg && res_valid_reg))
        else $error("frame end not handled");

endmodule

`default_nettype wire

@@ src/fbt_jump.sv @@
// ----------------------------------------------------------------------------
// fbt_jump
// Output register: clears a result whose corner jumped too far, packs it.
// ----------------------------------------------------------------------------
`default_nettype none

module fbt_jump (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             res_valid,
    output logic                                  res_ready,
    input  wire fbt_pkg::res_t                    res,
    input  wire logic [fbt_pkg::CW-1:0]           jump_limit,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [fbt_pkg::OUT_TDATA_W-1:0]       m_tdata,
    output logic                                  m_tuser
);

    localparam int CW     = fbt_pkg::CW;
    localparam int SW     = fbt_pkg::SW;
    localparam int JSQW   = fbt_pkg::JSQW;
    localparam int LIMSQW = fbt_pkg::LIMSQW;

    logic                           valid_reg;
    logic [fbt_pkg::OUT_FIELDS_W-1:0] fields_reg;
    logic                           found_reg;

    logic [SW-1:0]     dl, dt;
    logic [2*SW-1:0]   dl_sq, dt_sq;
    logic [JSQW-1:0]   jsq;
    logic [LIMSQW-1:0] jl_sq;
    logic              clear;
    logic [SW-1:0]     bx, by;
    logic [CW-1:0]     bw, bh;

    assign res_ready = !valid_reg || m_tready;

    assign dl    = (res.box_x > res.ref_left) ? (res.box_x - res.ref_left)
                                              : (res.ref_left - res.box_x);
    assign dt    = (res.box_y > res.ref_top) ? (res.box_y - res.ref_top)
                                             : (res.ref_top - res.box_y);
    assign dl_sq = dl * dl;
    assign dt_sq = dt * dt;
    assign jsq   = JSQW'(dl_sq) + JSQW'(dt_sq);
    assign jl_sq = jump_limit * jump_limit;
    assign clear = jsq > JSQW'(jl_sq);

    // Drop the box when the corner moved past the jump limit
    assign bx = clear ? '0 : res.box_x;
    assign by = clear ? '0 : res.box_y;
    assign bw = clear ? '0 : res.box_w;
    assign bh = clear ? '0 : res.box_h;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            fields_reg <= {bh, bw, by, bx};
            found_reg  <= (bx != '0) || (by != '0) || (bw != '0) || (bh != '0);
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = fbt_pkg::OUT_TDATA_W'(fields_reg);
    assign m_tuser  = found_reg;

endmodule

`default_nettype wire

@@ src/face_box_tracker_unit.sv @@
// ----------------------------------------------------------------------------
// face_box_tracker_unit
// Nearest-neighbor face box tracker: one chosen box per frame of detections.
// ----------------------------------------------------------------------------
//  Channel   Signals                        Moves
//  s_        tvalid tready tdata tuser tlast one detected box
//  m_        tvalid tready tdata tuser       one chosen box per frame
//  cfg_      valid ready index data          register write
//
//  One item is taken every cycle while m_ is not stalled; a frame's result
//  passes from the input register through the selection register to the
//  output register, which drives m_. The per-frame accumulator in fbt_select
//  is updated once per cycle while items flow and sets the rate.
//  rst_n clears mode, frame tracking and reference, resets limits at once.
//  A stalled m_ side stalls the pipeline stage by stage back to s_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module face_box_tracker_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // face_x, face_y, face_w, face_h, roi_x, roi_y (12 bits each, low first)
    input  wire logic [fbt_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // face_present
    input  wire logic                                s_tuser,
    input  wire logic                                s_tlast,
    // box_x, box_y (13 bits), box_w, box_h (12 bits), zero padded
    output logic [fbt_pkg::OUT_TDATA_W-1:0]          m_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // box_found
    output logic                                     m_tuser,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [fbt_pkg::CFG_IDXW-1:0]        cfg_index,
    input  wire logic [fbt_pkg::CW-1:0]              cfg_data
);

    logic [fbt_pkg::CW-1:0] jump_limit_reg;
    logic [fbt_pkg::CW-1:0] match_limit_reg;

    logic           cand_valid, cand_ready;
    fbt_pkg::cand_t cand;
    logic           res_valid, res_ready;
    fbt_pkg::res_t  res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jump_limit_reg  <= fbt_pkg::JUMP_LIMIT_RESET;
            match_limit_reg <= fbt_pkg::MATCH_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                fbt_pkg::REG_JUMP_LIMIT:  jump_limit_reg  <= cfg_data;
                fbt_pkg::REG_MATCH_LIMIT: match_limit_reg <= cfg_data;
                default:                  ;
            endcase
        end
    end

    fbt_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .cand_valid (cand_valid),
        .cand_ready (cand_ready),
        .cand       (cand)
    );

    fbt_select u_select (
        .clk         (clk),
        .rst_n       (rst_n),
        .cand_valid  (cand_valid),
        .cand_ready  (cand_ready),
        .cand        (cand),
        .match_limit (match_limit_reg),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    fbt_jump u_jump (
        .clk        (clk),
        .rst_n      (rst_n),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .jump_limit (jump_limit_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

`default_nettype wire
